@@ src/bpfl_pkg.sv @@
// Shared types and constants for the buffer pool free-list manager.
`timescale 1ns / 1ps

package bpfl_pkg;

	localparam int COUNT_W = 5;
	localparam int IDX_W   = 8;

	// Classified command passed from the front end to the executing back end.
	typedef struct packed {
		logic               is_rel;
		logic [COUNT_W-1:0] cnt;
		logic [IDX_W-1:0]   idx;
		logic               idx_ok;
		logic               blast;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_ACQ,
		ST_GRANT,
		ST_SPLICE
	} back_state_t;

endpackage

@@ src/bpfl_front.sv @@
// Front end: accepts request beats and classifies them into commands.
`timescale 1ns / 1ps

module bpfl_front #(
	parameter int NUM_BUFFERS = 256,
	parameter int MAX_REQUEST = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        ready_en,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic                        action,
	input  logic [bpfl_pkg::COUNT_W-1:0] count,
	input  logic [bpfl_pkg::IDX_W-1:0]  rel_index,
	input  logic                        batch_last,
	output logic                        cmd_valid,
	input  logic                        cmd_ready,
	output bpfl_pkg::cmd_t              cmd
);

	logic           v_s1;
	bpfl_pkg::cmd_t cmd_s1;
	bpfl_pkg::cmd_t cmd_d;
	logic           accept;

	assign req_ready = ready_en && (!v_s1 || cmd_ready);
	assign accept    = req_valid && req_ready;

	always_comb begin
		cmd_d.is_rel = action;
		// Requests above the limit are cut down to it.
		if (32'(count) > MAX_REQUEST) begin
			cmd_d.cnt = bpfl_pkg::COUNT_W'(MAX_REQUEST);
		end else begin
			cmd_d.cnt = count;
		end
		cmd_d.idx    = rel_index;
		cmd_d.idx_ok = (32'(rel_index) < NUM_BUFFERS);
		cmd_d.blast  = batch_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept || (v_s1 && !cmd_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

	assign cmd_valid = v_s1;
	assign cmd       = cmd_s1;

endmodule

@@ src/bpfl_queue.sv @@
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module bpfl_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  bpfl_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop,
	output bpfl_pkg::cmd_t pop_cmd
);

	bpfl_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_cmd    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ src/bpfl_back.sv @@
// Back end: link memory, free-list heads and the grant/release sequencer.
`timescale 1ns / 1ps

module bpfl_back #(
	parameter int NUM_BUFFERS = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	output logic                       init_done,
	input  logic                       cmd_valid,
	input  bpfl_pkg::cmd_t             cmd,
	output logic                       cmd_pop,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output logic [bpfl_pkg::IDX_W-1:0] granted_index,
	output logic                       granted,
	output logic                       last
);

	localparam int AW    = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
	localparam int PTR_W = $clog2(NUM_BUFFERS + 1);
	localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_BUFFERS);
	localparam logic [AW-1:0]    LAST_ADDR = AW'(NUM_BUFFERS - 1);

	bpfl_pkg::back_state_t state_q, state_d;

	logic [AW-1:0]    init_q, init_d;
	logic [PTR_W-1:0] acq_head_q, acq_head_d;
	logic [PTR_W-1:0] rel_head_q, rel_head_d;
	logic [PTR_W-1:0] bat_head_q, bat_head_d;
	logic [PTR_W-1:0] bat_tail_q, bat_tail_d;
	logic [bpfl_pkg::COUNT_W-1:0] rem_q, rem_d;
	logic             swapped_q, swapped_d;

	logic             out_valid_q;
	logic [bpfl_pkg::IDX_W-1:0] out_index_q;
	logic             out_granted_q;
	logic             out_last_q;

	logic             load_out;
	logic [bpfl_pkg::IDX_W-1:0] o_index;
	logic             o_granted;
	logic             o_last;
	logic             out_free;

	logic [PTR_W-1:0] link_mem [NUM_BUFFERS];
	logic [PTR_W-1:0] rdata_q;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [PTR_W-1:0] mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;

	logic [PTR_W-1:0] idx_p;
	logic             fin;

	assign out_free  = !out_valid_q || rsp_ready;
	assign idx_p     = PTR_W'(cmd.idx);
	assign init_done = (state_q != bpfl_pkg::ST_INIT);

	always_comb begin
		state_d    = state_q;
		init_d     = init_q;
		acq_head_d = acq_head_q;
		rel_head_d = rel_head_q;
		bat_head_d = bat_head_q;
		bat_tail_d = bat_tail_q;
		rem_d      = rem_q;
		swapped_d  = swapped_q;
		cmd_pop    = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = init_q;
		mem_wdata  = PTR_W'(init_q) + PTR_W'(1);
		mem_re     = 1'b0;
		mem_raddr  = acq_head_q[AW-1:0];
		load_out   = 1'b0;
		o_index    = '0;
		o_granted  = 1'b0;
		o_last     = 1'b1;
		fin        = 1'b0;

		unique case (state_q)
			bpfl_pkg::ST_INIT: begin
				// Clearing pass: every entry links to the next one, the last one to NIL.
				mem_we = 1'b1;
				init_d = init_q + AW'(1);
				if (init_q == LAST_ADDR) begin
					state_d = bpfl_pkg::ST_IDLE;
				end
			end
			bpfl_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.is_rel) begin
						if (cmd.idx_ok) begin
							if (bat_head_q >= NIL) begin
								bat_head_d = idx_p;
							end else if (bat_tail_q < NIL) begin
								mem_we    = 1'b1;
								mem_waddr = bat_tail_q[AW-1:0];
								mem_wdata = idx_p;
							end
							bat_tail_d = idx_p;
						end
						if (cmd.blast) begin
							state_d = bpfl_pkg::ST_SPLICE;
						end else begin
							cmd_pop = 1'b1;
						end
					end else begin
						rem_d     = cmd.cnt;
						swapped_d = 1'b0;
						if (cmd.cnt == '0) begin
							if (out_free) begin
								load_out = 1'b1;
								cmd_pop  = 1'b1;
							end
						end else begin
							state_d = bpfl_pkg::ST_ACQ;
						end
					end
				end
			end
			bpfl_pkg::ST_ACQ: begin
				if (acq_head_q < NIL) begin
					mem_re  = 1'b1;
					state_d = bpfl_pkg::ST_GRANT;
				end else if (!swapped_q && rel_head_q < NIL) begin
					acq_head_d = rel_head_q;
					rel_head_d = NIL;
					swapped_d  = 1'b1;
				end else if (out_free) begin
					// Both lists are empty: one beat with nothing granted.
					rel_head_d = NIL;
					load_out   = 1'b1;
					cmd_pop    = 1'b1;
					state_d    = bpfl_pkg::ST_IDLE;
				end
			end
			bpfl_pkg::ST_GRANT: begin
				fin = (rem_q == bpfl_pkg::COUNT_W'(1)) ||
					((rdata_q >= NIL) && (swapped_q || rel_head_q >= NIL));
				if (out_free) begin
					load_out   = 1'b1;
					o_index    = bpfl_pkg::IDX_W'(acq_head_q);
					o_granted  = 1'b1;
					o_last     = fin;
					acq_head_d = rdata_q;
					rem_d      = rem_q - bpfl_pkg::COUNT_W'(1);
					if (fin) begin
						cmd_pop = 1'b1;
						state_d = bpfl_pkg::ST_IDLE;
					end else begin
						if (rdata_q >= NIL) begin
							// Acquire list ran dry: continue on the release list.
							acq_head_d = rel_head_q;
							rel_head_d = NIL;
							swapped_d  = 1'b1;
						end
						state_d = bpfl_pkg::ST_ACQ;
					end
				end
			end
			bpfl_pkg::ST_SPLICE: begin
				if (bat_head_q < NIL && bat_tail_q < NIL) begin
					mem_we     = 1'b1;
					mem_waddr  = bat_tail_q[AW-1:0];
					mem_wdata  = rel_head_q;
					rel_head_d = bat_head_q;
				end
				bat_head_d = NIL;
				bat_tail_d = NIL;
				cmd_pop    = 1'b1;
				state_d    = bpfl_pkg::ST_IDLE;
			end
			default: begin
				state_d = bpfl_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bpfl_pkg::ST_INIT;
			init_q      <= '0;
			acq_head_q  <= '0;
			rel_head_q  <= NIL;
			bat_head_q  <= NIL;
			bat_tail_q  <= NIL;
			rem_q       <= '0;
			swapped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			init_q      <= init_d;
			acq_head_q  <= acq_head_d;
			rel_head_q  <= rel_head_d;
			bat_head_q  <= bat_head_d;
			bat_tail_q  <= bat_tail_d;
			rem_q       <= rem_d;
			swapped_q   <= swapped_d;
			out_valid_q <= load_out || (out_valid_q && !rsp_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_index_q   <= o_index;
			out_granted_q <= o_granted;
			out_last_q    <= o_last;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= link_mem[mem_raddr];
		end
	end

	assign rsp_valid     = out_valid_q;
	assign granted_index = out_index_q;
	assign granted       = out_granted_q;
	assign last          = out_last_q;

endmodule

@@ src/buffer_pool_free_list_manager_top.sv @@
// Top level of the buffer pool free-list manager.
//
//   Channel  Handshake              Beat contents
//   req      req_valid/req_ready    action, count, rel_index, batch_last
//   rsp      rsp_valid/rsp_ready    granted_index, granted, last
//
// An acquire is classified by the front end; in the back end each grant waits
// for the registered link-memory read that yields the next head, and moving
// the release list over before the first grant is a step of its own. A release
// element that closes a batch also passes through the splice state. After reset
// a clearing pass over all NUM_BUFFERS entries builds the initial chain;
// req_ready stays low until it ends. A two-entry command queue lets the
// front end keep taking beats while the back end waits on rsp_ready.
`timescale 1ns / 1ps

module buffer_pool_free_list_manager_top #(
	parameter int NUM_BUFFERS = 256,
	parameter int MAX_REQUEST = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic                         action,
	input  logic [bpfl_pkg::COUNT_W-1:0] count,
	input  logic [bpfl_pkg::IDX_W-1:0]   rel_index,
	input  logic                         batch_last,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output logic [bpfl_pkg::IDX_W-1:0]   granted_index,
	output logic                         granted,
	output logic                         last
);

	logic           init_done;
	logic           f_valid;
	logic           f_ready;
	bpfl_pkg::cmd_t f_cmd;
	logic           q_valid;
	logic           q_pop;
	bpfl_pkg::cmd_t q_cmd;

	bpfl_front #(
		.NUM_BUFFERS(NUM_BUFFERS),
		.MAX_REQUEST(MAX_REQUEST)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.ready_en    (init_done),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.action      (action),
		.count       (count),
		.rel_index   (rel_index),
		.batch_last  (batch_last),
		.cmd_valid   (f_valid),
		.cmd_ready   (f_ready),
		.cmd         (f_cmd)
	);

	bpfl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_cmd  (f_cmd),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_cmd   (q_cmd)
	);

	bpfl_back #(
		.NUM_BUFFERS(NUM_BUFFERS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.init_done    (init_done),
		.cmd_valid    (q_valid),
		.cmd          (q_cmd),
		.cmd_pop      (q_pop),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.granted_index(granted_index),
		.granted      (granted),
		.last         (last)
	);

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the buffer pool free-list manager.
`timescale 1ns / 1ps

module testbench;

	localparam int NBUF = 256;
	localparam int MAX_REQ = 16;
	localparam logic [8:0] NIL = 9'(NBUF);
	localparam logic ACT_ACQUIRE = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 185;

	typedef struct packed {
		logic                         action;
		logic [bpfl_pkg::COUNT_W-1:0] count;
		logic [bpfl_pkg::IDX_W-1:0]   rel_index;
		logic                         batch_last;
	} req_t;

	typedef struct packed {
		logic [bpfl_pkg::IDX_W-1:0] idx;
		logic                       granted;
		logic                       last;
	} grant_t;

	typedef struct packed {
		req_t                       req;
		logic                       typed;
		logic [bpfl_pkg::IDX_W-1:0] first;
		logic [4:0]                 n;
	} row_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         req_valid = 1'b0;
	logic                         req_ready;
	logic                         action = 1'b0;
	logic [bpfl_pkg::COUNT_W-1:0] count = '0;
	logic [bpfl_pkg::IDX_W-1:0]   rel_index = '0;
	logic                         batch_last = 1'b0;
	logic                         rsp_valid;
	logic                         rsp_ready = 1'b0;
	logic [bpfl_pkg::IDX_W-1:0]   granted_index;
	logic                         granted;
	logic                         last;

	buffer_pool_free_list_manager_top #(
		.NUM_BUFFERS(NBUF),
		.MAX_REQUEST(MAX_REQ)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.action(action),
		.count(count),
		.rel_index(rel_index),
		.batch_last(batch_last),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.granted_index(granted_index),
		.granted(granted),
		.last(last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow copy of the free lists.
	logic [8:0] link_mem [NBUF];
	logic [8:0] acq_head, rel_head, bat_head, bat_tail;

	grant_t     step_out [$];
	grant_t     grant_q [$];
	logic [7:0] owned_bufs [$];
	row_t       plan [$];

	int errors = 0;
	int n_items = 0, n_acq = 0, n_rel = 0, n_grants = 0, n_empty = 0, n_moves = 0;
	int burst_left = 0;
	int ready_pct = 100;
	int phase_cycles = 0;
	int idle_cycles = 0;

	task automatic flag(input string msg);
		errors++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	function automatic void pool_reset();
		for (int i = 0; i < NBUF; i++)
			link_mem[i] = 9'(i + 1);
		acq_head = '0;
		rel_head = NIL;
		bat_head = NIL;
		bat_tail = NIL;
	endfunction

	function automatic logic [8:0] next_of(input logic [8:0] node);
		return (node >= NIL) ? NIL : link_mem[node[7:0]];
	endfunction

	// Computes the beats one request produces and advances the shadow lists.
	function automatic void pool_step(input req_t r);
		int want;
		int got;
		logic [8:0] hd;
		step_out.delete();
		if (r.action == ACT_ACQUIRE) begin
			n_acq++;
			want = (r.count > MAX_REQ) ? MAX_REQ : int'(r.count);
			got = 0;
			if (want != 0) begin
				hd = acq_head;
				while (got < want && hd < NIL) begin
					step_out.push_back('{idx: hd[7:0], granted: 1'b1, last: 1'b0});
					got++;
					hd = next_of(hd);
				end
				if (got < want) begin
					// The acquire list ran dry, so the whole release list moves over.
					if (rel_head != NIL)
						n_moves++;
					hd = rel_head;
					rel_head = NIL;
					while (got < want && hd < NIL) begin
						step_out.push_back('{idx: hd[7:0], granted: 1'b1, last: 1'b0});
						got++;
						hd = next_of(hd);
					end
				end
				acq_head = hd;
			end
			if (got == 0) begin
				step_out.push_back('{idx: 8'd0, granted: 1'b0, last: 1'b1});
				n_empty++;
			end else begin
				step_out[got-1].last = 1'b1;
				n_grants += got;
			end
		end else begin
			n_rel++;
			if (bat_head >= NIL)
				bat_head = {1'b0, r.rel_index};
			else if (bat_tail < NIL)
				link_mem[bat_tail[7:0]] = {1'b0, r.rel_index};
			bat_tail = {1'b0, r.rel_index};
			if (r.batch_last) begin
				link_mem[bat_tail[7:0]] = rel_head;
				rel_head = bat_head;
				bat_head = NIL;
				bat_tail = NIL;
			end
		end
	endfunction

	function automatic void add_row(input logic act, input logic [4:0] cnt,
			input logic [7:0] idx, input logic bl, input logic typed,
			input logic [7:0] first, input logic [4:0] n);
		plan.push_back('{req: '{action: act, count: cnt, rel_index: idx, batch_last: bl},
			typed: typed, first: first, n: n});
	endfunction

	// Drives one request beat, waits for it to be taken, then queues its results.
	task automatic send_req(input req_t r, input logic typed, input logic [7:0] first,
			input int n);
		int hit;
		req_valid <= 1'b1;
		action <= r.action;
		count <= r.count;
		rel_index <= r.rel_index;
		batch_last <= r.batch_last;
		do @(posedge clk); while (!req_ready);
		n_items++;
		pool_step(r);
		if (typed) begin
			if (r.action == ACT_ACQUIRE && n == 0)
				grant_q.push_back('{idx: 8'd0, granted: 1'b0, last: 1'b1});
			for (int k = 0; k < n; k++)
				grant_q.push_back('{idx: 8'(first + k), granted: 1'b1, last: (k == n - 1)});
		end else begin
			foreach (step_out[k])
				grant_q.push_back(step_out[k]);
		end
		foreach (step_out[k])
			if (step_out[k].granted)
				owned_bufs.push_back(step_out[k].idx);
		if (r.action == ACT_RELEASE) begin
			hit = -1;
			foreach (owned_bufs[k])
				if (owned_bufs[k] == r.rel_index) begin
					hit = k;
					break;
				end
			if (hit >= 0)
				owned_bufs.delete(hit);
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
		end
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (grant_q.size() != 0);
	endtask

	// Response checker and receiver stall pattern.
	always @(posedge clk) begin
		grant_t want;
		if (rsp_valid && rsp_ready) begin
			if (grant_q.size() == 0) begin
				flag($sformatf("unexpected beat idx=%0d granted=%b last=%b",
					granted_index, granted, last));
			end else begin
				want = grant_q.pop_front();
				if (granted_index !== want.idx)
					flag($sformatf("granted_index %0d, expected %0d", granted_index, want.idx));
				if (granted !== want.granted)
					flag($sformatf("granted %b, expected %b", granted, want.granted));
				if (last !== want.last)
					flag($sformatf("last %b, expected %b", last, want.last));
			end
		end
		if (phase_cycles == 0) begin
			case ($urandom_range(0, 3))
				0: ready_pct = 100;
				1: ready_pct = 70;
				2: ready_pct = 35;
				default: ready_pct = 15;
			endcase
			phase_cycles = $urandom_range(20, 80);
		end else begin
			phase_cycles--;
		end
		rsp_ready <= ($urandom_range(1, 100) <= ready_pct);
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("ERROR: no beat moved for %0d cycles", IDLE_LIMIT);
			$display("buffer_pool_free_list_manager_top: mismatch");
			$finish;
		end
	end

	initial begin
		req_t r;
		logic batch_open;
		int pick;
		int pos;

		pool_reset();
		batch_open = 1'b0;

		// After reset the acquire list holds 0..255 in order.
		add_row(ACT_ACQUIRE, 5'd1, 8'd0, 1'b0, 1'b1, 8'd0, 5'd1);
		add_row(ACT_ACQUIRE, 5'd0, 8'd0, 1'b0, 1'b1, 8'd0, 5'd0);
		add_row(ACT_ACQUIRE, 5'd31, 8'd255, 1'b1, 1'b1, 8'd1, 5'd16);
		add_row(ACT_ACQUIRE, 5'd16, 8'd0, 1'b0, 1'b1, 8'd17, 5'd16);
		add_row(ACT_RELEASE, 5'd0, 8'd0, 1'b1, 1'b1, 8'd0, 5'd0);
		add_row(ACT_RELEASE, 5'd31, 8'd5, 1'b0, 1'b1, 8'd0, 5'd0);
		add_row(ACT_RELEASE, 5'd0, 8'd3, 1'b0, 1'b1, 8'd0, 5'd0);
		add_row(ACT_RELEASE, 5'd0, 8'd1, 1'b1, 1'b1, 8'd0, 5'd0);
		// Drain the acquire list; the last of these pulls in the release list.
		for (int i = 0; i < 14; i++)
			add_row(ACT_ACQUIRE, 5'd16, 8'd0, 1'b0, 1'b0, 8'd0, 5'd0);
		add_row(ACT_RELEASE, 5'd0, 8'd255, 1'b1, 1'b1, 8'd0, 5'd0);
		// An open batch is in neither list, so buffer 2 cannot be granted yet.
		add_row(ACT_RELEASE, 5'd0, 8'd2, 1'b0, 1'b1, 8'd0, 5'd0);
		add_row(ACT_ACQUIRE, 5'd16, 8'd0, 1'b0, 1'b0, 8'd0, 5'd0);
		add_row(ACT_ACQUIRE, 5'd1, 8'd0, 1'b0, 1'b1, 8'd0, 5'd0);
		add_row(ACT_RELEASE, 5'd0, 8'd200, 1'b1, 1'b1, 8'd0, 5'd0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_req(plan[i].req, plan[i].typed, plan[i].first, int'(plan[i].n));
		wait_drained();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			if (owned_bufs.size() != 0 && ((batch_open && pick < 75) || (!batch_open && pick < 60)))
			begin
				r.action = ACT_RELEASE;
				r.count = 5'($urandom_range(0, 31));
				if ($urandom_range(0, 99) < 4) begin
					// Occasional release of an arbitrary index, possibly one already free.
					r.rel_index = 8'($urandom_range(0, 255));
				end else begin
					pos = $urandom_range(0, owned_bufs.size() - 1);
					r.rel_index = owned_bufs[pos];
				end
				r.batch_last = ($urandom_range(0, 99) < 35);
				batch_open = !r.batch_last;
			end else begin
				r.action = ACT_ACQUIRE;
				r.rel_index = 8'($urandom_range(0, 255));
				r.batch_last = 1'($urandom_range(0, 1));
				pick = $urandom_range(0, 99);
				if (pick < 4)
					r.count = 5'd0;
				else if (pick < 8)
					r.count = 5'($urandom_range(17, 31));
				else if (pick < 18)
					r.count = 5'($urandom_range(9, 16));
				else
					r.count = 5'($urandom_range(1, 8));
			end
			send_req(r, 1'b0, 8'd0, 0);
			if (i % 60 == 59)
				wait_drained();
		end

		wait_drained();
		repeat (64) @(posedge clk);
		if (grant_q.size() != 0)
			flag($sformatf("%0d expected beats never arrived", grant_q.size()));
		$display("Sent %0d requests: %0d acquires, %0d release elements.",
			n_items, n_acq, n_rel);
		$display("Checked %0d granted buffers, %0d empty replies, %0d release list moves.",
			n_grants, n_empty, n_moves);
		if (errors == 0)
			$display("buffer_pool_free_list_manager_top: match");
		else
			$display("buffer_pool_free_list_manager_top: mismatch");
		$finish;
	end

endmodule
